[rtl/lif_neuron_update_macros.svh]
// assertion macros for the lif neuron update block
// expects clk and rst in the scope of each use
`ifndef LIF_NEURON_UPDATE_MACROS_SVH
`define LIF_NEURON_UPDATE_MACROS_SVH

// same-cycle implication
`define LIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lif_neuron_update: check failed");

// next-cycle implication
`define LIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lif_neuron_update: check failed");

`endif

[rtl/lif_pkg.sv]
// shared constants, types and saturating fixed-point helpers
// no dependencies
package lif_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 15;
  localparam int LANE_W = 2;                 // fields carried per lane
  localparam int MUL_W  = DATA_W + 1;        // signed operand width
  localparam int PROD_W = 2 * MUL_W;

  localparam int NUM_EXC = 2;
  localparam int NUM_INH = 2;
  localparam int EXC_USED = (NUM_EXC > LANE_W) ? LANE_W : ((NUM_EXC < 0) ? 0 : NUM_EXC);
  localparam int INH_USED = (NUM_INH > LANE_W) ? LANE_W : ((NUM_INH < 0) ? 0 : NUM_INH);
  localparam logic [LANE_W-1:0] EXC_MASK = LANE_W'((1 << EXC_USED) - 1);
  localparam logic [LANE_W-1:0] INH_MASK = LANE_W'((1 << INH_USED) - 1);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  function automatic fix_t sat_add(input fix_t a, input fix_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] == s[DATA_W-1]) return s[DATA_W-1:0];
    return s[DATA_W] ? S_MIN : S_MAX;
  endfunction

  function automatic fix_t sat_sub(input fix_t a, input fix_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] == s[DATA_W-1]) return s[DATA_W-1:0];
    return s[DATA_W] ? S_MIN : S_MAX;
  endfunction

  // drop fraction bits (floor), then saturate
  function automatic fix_t prod_to_fix(input prod_t p);
    logic [PROD_W-FRAC_W-1:0] q;
    logic [PROD_W-FRAC_W-DATA_W:0] top;
    q = p[PROD_W-1:FRAC_W];
    top = q[PROD_W-FRAC_W-1:DATA_W-1];
    if ((&top) || !(|top)) return q[DATA_W-1:0];
    return q[PROD_W-FRAC_W-1] ? S_MIN : S_MAX;
  endfunction

endpackage

[rtl/lif_neuron_update.sv]
// leaky integrate-and-fire neuron update, top level with control sequencer
// depends on lif_pkg, lif_sum_lane, lif_merge, lif_mul and the macro header
// timestep item while not refractory: merge, first product, alpha, second product and update; no new item until done
// spike item or refractory timestep: the result is registered at the merge step; no new item until it finishes
// the two dependent products share one multiplier, so the two product steps run in turn
// the output register frees the input side: a new item is taken while a result waits
// synchronous reset clears voltage, refractory count, configuration registers and handshake state
`include "lif_neuron_update_macros.svh"

module lif_neuron_update (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic signed [31:0] exc_current_0,
  input  logic signed [31:0] exc_current_1,
  input  logic signed [31:0] inh_current_0,
  input  logic signed [31:0] inh_current_1,
  input  logic signed [31:0] bias_current,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] membrane_voltage,
  output logic        in_refractory
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_MERGE,  // lanes done, current being merged; short items finish here
    S_MUL1,   // current * resistance
    S_ALPHA,  // alpha and difference to the stored voltage
    S_MUL2,   // decay * difference
    S_UPD     // new voltage, finish
  } state_t;

  typedef enum logic [2:0] {
    REG_REST   = 3'd0,
    REG_RESET  = 3'd1,
    REG_OFFSET = 3'd2,
    REG_RES    = 3'd3,
    REG_DECAY  = 3'd4,
    REG_STEPS  = 3'd5
  } reg_idx_t;

  state_t state;

  // configuration registers
  lif_pkg::fix_t rest_voltage;
  lif_pkg::fix_t reset_voltage;
  lif_pkg::fix_t offset_current;
  logic [30:0]   membrane_resistance;
  logic [15:0]   decay_factor;
  logic [15:0]   refractory_steps;

  // neuron state
  lif_pkg::fix_t voltage;
  logic [15:0]   refr_count;

  // per-item working registers
  logic          op_q;
  lif_pkg::fix_t bias_q;
  lif_pkg::fix_t alpha_q;
  lif_pkg::fix_t diff_q;

  lif_pkg::fix_t exc_vals [lif_pkg::LANE_W];
  lif_pkg::fix_t inh_vals [lif_pkg::LANE_W];
  lif_pkg::fix_t exc_sum, inh_sum, current;
  lif_pkg::prod_t   prod;
  lif_pkg::mul_req_t mul_req;

  logic          in_acc;
  logic          out_free;
  logic          short_item;
  logic          finish;
  lif_pkg::fix_t prod_fix;
  lif_pkg::fix_t alpha_next, diff_next;
  lif_pkg::fix_t v_fin;
  logic [15:0]   cnt_fin;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  // the output slot can take a result this cycle
  assign out_free  = !out_valid || out_ready;

  assign exc_vals[0] = exc_current_0;
  assign exc_vals[1] = exc_current_1;
  assign inh_vals[0] = inh_current_0;
  assign inh_vals[1] = inh_current_1;

  // lanes sum the excitatory and inhibitory inputs side by side at acceptance
  lif_sum_lane u_exc_lane (
    .clk      (clk),
    .load     (in_acc),
    .vals     (exc_vals),
    .use_mask (lif_pkg::EXC_MASK),
    .sum      (exc_sum)
  );

  lif_sum_lane u_inh_lane (
    .clk      (clk),
    .load     (in_acc),
    .vals     (inh_vals),
    .use_mask (lif_pkg::INH_MASK),
    .sum      (inh_sum)
  );

  lif_merge u_merge (
    .clk     (clk),
    .load    (state == S_MERGE),
    .exc_sum (exc_sum),
    .inh_sum (inh_sum),
    .bias    (bias_q),
    .offset  (offset_current),
    .current (current)
  );

  // one multiplier, used twice per timestep item outside the refractory period
  always_comb begin
    mul_req.en = (state == S_MUL1) || (state == S_MUL2);
    if (state == S_MUL1) begin
      mul_req.a = {current[31], current};
      mul_req.b = {2'b00, membrane_resistance};
    end else begin
      mul_req.a = {17'd0, decay_factor};
      mul_req.b = {diff_q[31], diff_q};
    end
  end

  lif_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign prod_fix   = lif_pkg::prod_to_fix(prod);
  assign alpha_next = lif_pkg::sat_add(prod_fix, rest_voltage);
  assign diff_next  = lif_pkg::sat_sub(alpha_q, voltage);

  // spike items and refractory timesteps skip the arithmetic
  assign short_item = op_q || (refr_count != 16'd0);

  always_comb begin
    v_fin   = voltage;
    cnt_fin = refr_count;
    if (state == S_UPD) begin
      v_fin = lif_pkg::sat_sub(alpha_q, prod_fix);
    end else if (op_q) begin
      v_fin   = reset_voltage;
      cnt_fin = refractory_steps;
    end else begin
      cnt_fin = refr_count - 16'd1;
    end
  end

  // finishing steps wait here until the output register is free
  assign finish = out_free && ((state == S_UPD) || ((state == S_MERGE) && short_item));

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      out_valid           <= 1'b0;
      voltage             <= '0;
      refr_count          <= '0;
      rest_voltage        <= '0;
      reset_voltage       <= '0;
      offset_current      <= '0;
      membrane_resistance <= '0;
      decay_factor        <= '0;
      refractory_steps    <= '0;
    end else begin
      // the user must write registers only while no item is in flight; the block itself does not enforce this
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_REST:   rest_voltage        <= cfg_data;
          REG_RESET:  reset_voltage       <= cfg_data;
          REG_OFFSET: offset_current      <= cfg_data;
          REG_RES:    membrane_resistance <= cfg_data[30:0];
          REG_DECAY:  decay_factor        <= cfg_data[15:0];
          REG_STEPS:  refractory_steps    <= cfg_data[15:0];
          default: ;
        endcase
      end

      // a new result refills the slot in the cycle the old one leaves
      if (finish) begin
        voltage          <= v_fin;
        refr_count       <= cnt_fin;
        out_valid        <= 1'b1;
        membrane_voltage <= v_fin;
        in_refractory    <= (cnt_fin != 16'd0);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_q   <= opcode;
            bias_q <= bias_current;
            state  <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!short_item) state <= S_MUL1;
          else if (finish) state <= S_IDLE;
        end
        S_MUL1: state <= S_ALPHA;
        S_ALPHA: begin
          alpha_q <= alpha_next;
          diff_q  <= lif_pkg::sat_sub(alpha_next, voltage);
          state   <= S_MUL2;
        end
        S_MUL2: state <= S_UPD;
        S_UPD: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // accepted item always starts at the merge step
  `LIF_ASSERT_NXT(a_accept_to_merge, in_valid && in_ready, state == S_MERGE)

  // a refractory timestep counts down by one and keeps the voltage
  `LIF_ASSERT_NXT(a_refr_countdown,
    state == S_MERGE && !op_q && refr_count != 16'd0 && out_free,
    refr_count == $past(refr_count) - 16'd1 && voltage == $past(voltage) && out_valid)

  // a spike item loads the reset voltage and reports the refractory flag
  `LIF_ASSERT_NXT(a_spike_load,
    state == S_MERGE && op_q && out_free,
    voltage == $past(reset_voltage) &&
    in_refractory == ($past(refractory_steps) != 16'd0))

  // a published result always matches the stored voltage
  `LIF_ASSERT_NXT(a_out_matches_state, finish, membrane_voltage == voltage && out_valid)

  // difference used by the second product follows from alpha and the voltage
  `LIF_ASSERT_IMP(a_diff_consistent, state == S_MUL2, diff_q == diff_next)

endmodule

[rtl/lif_sum_lane.sv]
// one input lane: saturating sum of the synaptic currents of one kind
// depends on lif_pkg
module lif_sum_lane (
  input  logic                clk,
  input  logic                load,
  input  lif_pkg::fix_t       vals [lif_pkg::LANE_W],
  input  logic [lif_pkg::LANE_W-1:0] use_mask,
  output lif_pkg::fix_t       sum
);

  lif_pkg::fix_t acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < lif_pkg::LANE_W; i++) begin
      if (use_mask[i]) acc = lif_pkg::sat_add(acc, vals[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) sum <= acc;
  end

endmodule

[rtl/lif_merge.sv]
// merges the lane sums with bias and offset into the input current
// depends on lif_pkg
module lif_merge (
  input  logic          clk,
  input  logic          load,
  input  lif_pkg::fix_t exc_sum,
  input  lif_pkg::fix_t inh_sum,
  input  lif_pkg::fix_t bias,
  input  lif_pkg::fix_t offset,
  output lif_pkg::fix_t current
);

  lif_pkg::fix_t c0, c1, c2;

  always_comb begin
    c0 = lif_pkg::sat_sub(exc_sum, inh_sum);
    c1 = lif_pkg::sat_add(c0, bias);
    c2 = lif_pkg::sat_add(c1, offset);
  end

  always_ff @(posedge clk) begin
    if (load) current <= c2;
  end

endmodule

[rtl/lif_mul.sv]
// shared signed multiplier with registered product
// depends on lif_pkg
module lif_mul (
  input  logic              clk,
  input  lif_pkg::mul_req_t req,
  output lif_pkg::prod_t    prod
);

  always_ff @(posedge clk) begin
    if (req.en) prod <= req.a * req.b;
  end

endmodule
